@@ hw/rtl/ssp_pkg.sv @@
// Shared types and constants for the size suffix string parser.
// Holds the character codes, phase and radix encodings, status codes and
// the finish request that travels from the parser to the scaling pipeline.
package ssp_pkg;

    localparam int CH_W    = 8;
    localparam int VAL_W   = 64;
    localparam int SH_W    = 6;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam int HALF_W  = VAL_W / 2;

    // Output beat: status, size, unit, padded to whole bytes.
    localparam int OUT_BITS = 2 + VAL_W + VAL_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};

    // Register select taken from paddr[3] (registers sit at 8-byte steps).
    localparam logic REG_B_MEANS_BYTES = 1'b0;
    localparam logic REG_DEFAULT_UNIT  = 1'b1;

    // Character codes.
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_1     = 8'h31;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UF    = 8'h46;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LF    = 8'h66;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [CH_W-1:0] CH_LB    = 8'h62;
    localparam logic [CH_W-1:0] CH_UK    = 8'h4B;
    localparam logic [CH_W-1:0] CH_LK    = 8'h6B;
    localparam logic [CH_W-1:0] CH_UM    = 8'h4D;
    localparam logic [CH_W-1:0] CH_LM    = 8'h6D;
    localparam logic [CH_W-1:0] CH_UG    = 8'h47;
    localparam logic [CH_W-1:0] CH_LG    = 8'h67;
    localparam logic [CH_W-1:0] CH_UT    = 8'h54;
    localparam logic [CH_W-1:0] CH_LT    = 8'h74;
    localparam logic [CH_W-1:0] CH_UP    = 8'h50;
    localparam logic [CH_W-1:0] CH_LP    = 8'h70;
    localparam logic [CH_W-1:0] CH_UE    = 8'h45;
    localparam logic [CH_W-1:0] CH_LE    = 8'h65;

    // Suffix shift amounts.
    localparam logic [SH_W-1:0] SH_BYTE  = 6'd0;
    localparam logic [SH_W-1:0] SH_BLOCK = 6'd9;
    localparam logic [SH_W-1:0] SH_KILO  = 6'd10;
    localparam logic [SH_W-1:0] SH_MEGA  = 6'd20;
    localparam logic [SH_W-1:0] SH_GIGA  = 6'd30;
    localparam logic [SH_W-1:0] SH_TERA  = 6'd40;
    localparam logic [SH_W-1:0] SH_PETA  = 6'd50;
    localparam logic [SH_W-1:0] SH_EXA   = 6'd60;

    typedef enum logic [5:0] {
        PH_LEAD   = 6'b000001,
        PH_SIGNED = 6'b000010,
        PH_PREFIX = 6'b000100,
        PH_DIGITS = 6'b001000,
        PH_SUFFIX = 6'b010000,
        PH_ERROR  = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_BAD = 2'd1,
        ST_OVF = 2'd2
    } status_t;

    // Finish request: when mul_en is set, size holds the accumulator and
    // unit the multiplier; otherwise size and unit are final.
    typedef struct packed {
        status_t          status;
        logic             mul_en;
        logic [VAL_W-1:0] size;
        logic [VAL_W-1:0] unit;
    } fin_t;

endpackage

@@ hw/rtl/size_suffix_string_parser.sv @@
// Top level of the size suffix string parser: stream ports, configuration
// registers and the parser feeding the scaling pipeline.
// Depends on ssp_pkg, ssp_parser and ssp_scaler.

// The block reads a size string one character per request on the s_ stream
// and answers each terminating NUL with one request on the m_ stream that
// carries the status (ok, malformed, overflow), the size in bytes and the
// unit applied. Leading whitespace and a plus sign are accepted; numbers may
// be decimal, octal with a leading 0, or hex after 0x, and may carry one
// suffix: b (512-byte blocks, or bytes when b_means_bytes is set) or K, M, G,
// T, P, E in either case for powers of 1024. With no suffix the number is
// multiplied by default_unit (zero counts as one), keeping the low 64 bits.
// The block accepts one character every clock cycle while s_tready is high;
// each one updates the parse state registers. The result of a NUL is offered
// on m_tvalid after it passes the first stage registers, which take the
// 32-bit partial products of the default-unit multiply, and the output
// register, which takes their sum. Back-pressure on m_tready holds the pipeline
// and reaches s_tready only once both result stages are full. Registers sit
// at byte address 0 (b_means_bytes) and 8 (default_unit) on a 64-bit
// register port and should be written only while no string is in progress.
module size_suffix_string_parser (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ssp_pkg::CH_W-1:0]        s_tdata,   // [7:0] ch

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ssp_pkg::OUT_W-1:0]       m_tdata,   // [1:0] status, [65:2] size_bytes,
                                                       // [129:66] unit_bytes, rest zero

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ssp_pkg::PADDR_W-1:0]     paddr,
    input  logic [ssp_pkg::PDATA_W-1:0]     pwdata,
    output logic [ssp_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    logic                           b_means_bytes_reg;
    logic [ssp_pkg::VAL_W-1:0]      default_unit_reg;
    logic                           cfg_write;
    logic                           in_fire;
    logic                           fin_valid;
    logic                           fin_ready;
    ssp_pkg::fin_t                  fin;
    logic [1:0]                     out_status;
    logic [ssp_pkg::VAL_W-1:0]      out_size;
    logic [ssp_pkg::VAL_W-1:0]      out_unit;

    // Register port: zero wait states; the select is paddr[3] since the
    // registers lie 8 bytes apart.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_means_bytes_reg <= 1'b0;
            default_unit_reg  <= '0;
        end else if (cfg_write) begin
            unique case (paddr[3])
                ssp_pkg::REG_B_MEANS_BYTES: b_means_bytes_reg <= pwdata[0];
                ssp_pkg::REG_DEFAULT_UNIT:  default_unit_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            ssp_pkg::REG_B_MEANS_BYTES:
                prdata = {{(ssp_pkg::PDATA_W-1){1'b0}}, b_means_bytes_reg};
            ssp_pkg::REG_DEFAULT_UNIT:
                prdata = default_unit_reg;
            default:
                prdata = '0;
        endcase
    end

    // A character request is taken whenever the first result stage can take
    // a result, so ordinary characters never wait on the parser itself.
    assign s_tready  = fin_ready;
    assign in_fire   = s_tvalid && s_tready;
    assign fin_valid = in_fire && (s_tdata == ssp_pkg::CH_NUL);

    ssp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .ch            (s_tdata),
        .b_means_bytes (b_means_bytes_reg),
        .default_unit  (default_unit_reg),
        .fin           (fin)
    );

    ssp_scaler u_scaler (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fin_valid  (fin_valid),
        .fin        (fin),
        .fin_ready  (fin_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_size   (out_size),
        .out_unit   (out_unit)
    );

    // Result packing: status in the low bits, then size, then unit.
    assign m_tdata = {{(ssp_pkg::OUT_W-ssp_pkg::OUT_BITS){1'b0}},
                      out_unit, out_size, out_status};

endmodule

@@ hw/rtl/ssp_parser.sv @@
// Character parser of the size suffix string parser: parse state registers
// and the finish decision taken when the terminating NUL arrives.
// Depends on ssp_pkg.
module ssp_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_fire,
    input  logic [ssp_pkg::CH_W-1:0]    ch,
    input  logic                        b_means_bytes,
    input  logic [ssp_pkg::VAL_W-1:0]   default_unit,
    output ssp_pkg::fin_t               fin
);

    ssp_pkg::phase_t                phase_reg, phase_next;
    ssp_pkg::radix_t                radix_reg, radix_next;
    logic [ssp_pkg::VAL_W-1:0]      acc_reg, acc_next;
    logic                           digit_seen_reg, digit_seen_next;
    logic                           ovf_reg, ovf_next;
    logic [ssp_pkg::CH_W-1:0]       suffix_reg, suffix_next;

    logic                           is_ws;
    logic                           is_num;
    logic                           is_alpha;
    logic [3:0]                     dval;
    logic                           dig_ok;
    logic [ssp_pkg::VAL_W+3:0]      scaled;
    logic [ssp_pkg::VAL_W+3:0]      prod;
    logic                           add_ovf;
    logic [ssp_pkg::VAL_W-1:0]      add_acc;
    logic                           do_first;
    logic                           do_digits;
    logic                           do_add;

    // Character classes and digit value in the current radix.
    always_comb begin
        is_ws    = (ch == ssp_pkg::CH_SPACE) ||
                   (ch >= ssp_pkg::CH_TAB && ch <= ssp_pkg::CH_CR);
        is_num   = (ch >= ssp_pkg::CH_0 && ch <= ssp_pkg::CH_9);
        is_alpha = (ch >= ssp_pkg::CH_LA && ch <= ssp_pkg::CH_LF) ||
                   (ch >= ssp_pkg::CH_UA && ch <= ssp_pkg::CH_UF);
        dval     = is_num ? ch[3:0] : 4'(ch[3:0] + 4'd9);
        unique case (radix_reg)
            ssp_pkg::RADIX_HEX: dig_ok = is_num || is_alpha;
            ssp_pkg::RADIX_OCT: dig_ok = is_num && !dval[3];
            ssp_pkg::RADIX_DEC: dig_ok = is_num;
            default:            dig_ok = 1'b0;
        endcase
    end

    // Accumulate one digit: acc * base + digit in 68 bits, so any carry
    // into the top nibble means the 64-bit value overflowed.
    always_comb begin
        unique case (radix_reg)
            ssp_pkg::RADIX_HEX: scaled = {acc_reg, 4'b0000};
            ssp_pkg::RADIX_OCT: scaled = {1'b0, acc_reg, 3'b000};
            ssp_pkg::RADIX_DEC: scaled = {1'b0, acc_reg, 3'b000} +
                                         {3'b000, acc_reg, 1'b0};
            default:            scaled = '0;
        endcase
        prod    = scaled + {{ssp_pkg::VAL_W{1'b0}}, dval};
        add_ovf = ovf_reg || (prod[ssp_pkg::VAL_W+3:ssp_pkg::VAL_W] != 4'd0);
        add_acc = add_ovf ? ssp_pkg::ALL_ONES : prod[ssp_pkg::VAL_W-1:0];
    end

    // Next parse state for one accepted character.
    always_comb begin
        phase_next      = phase_reg;
        radix_next      = radix_reg;
        acc_next        = acc_reg;
        digit_seen_next = digit_seen_reg;
        ovf_next        = ovf_reg;
        suffix_next     = suffix_reg;
        do_first        = 1'b0;
        do_digits       = 1'b0;
        do_add          = 1'b0;

        unique case (phase_reg) inside
            ssp_pkg::PH_LEAD: begin
                if (is_ws) begin
                    phase_next = ssp_pkg::PH_LEAD;
                end else if (ch == ssp_pkg::CH_MINUS) begin
                    phase_next = ssp_pkg::PH_ERROR;
                end else if (ch == ssp_pkg::CH_PLUS) begin
                    phase_next = ssp_pkg::PH_SIGNED;
                end else begin
                    do_first = 1'b1;
                end
            end
            ssp_pkg::PH_SIGNED: begin
                do_first = 1'b1;
            end
            ssp_pkg::PH_PREFIX: begin
                if (radix_reg == ssp_pkg::RADIX_HEX) begin
                    if (dig_ok) begin
                        do_add     = 1'b1;
                        phase_next = ssp_pkg::PH_DIGITS;
                    end else begin
                        phase_next = ssp_pkg::PH_ERROR;
                    end
                end else if (ch == ssp_pkg::CH_LX || ch == ssp_pkg::CH_UX) begin
                    radix_next = ssp_pkg::RADIX_HEX;
                end else begin
                    do_digits = 1'b1;
                end
            end
            ssp_pkg::PH_DIGITS: begin
                do_digits = 1'b1;
            end
            ssp_pkg::PH_SUFFIX, ssp_pkg::PH_ERROR: begin
                phase_next = ssp_pkg::PH_ERROR;
            end
            default: begin
                phase_next = ssp_pkg::PH_ERROR;
            end
        endcase

        // First character of the number: the accumulator is still zero here.
        if (do_first) begin
            if (ch == ssp_pkg::CH_0) begin
                phase_next      = ssp_pkg::PH_PREFIX;
                radix_next      = ssp_pkg::RADIX_OCT;
                digit_seen_next = 1'b1;
            end else if (ch >= ssp_pkg::CH_1 && ch <= ssp_pkg::CH_9) begin
                phase_next      = ssp_pkg::PH_DIGITS;
                radix_next      = ssp_pkg::RADIX_DEC;
                acc_next        = {{(ssp_pkg::VAL_W-4){1'b0}}, ch[3:0]};
                digit_seen_next = 1'b1;
            end else begin
                phase_next = ssp_pkg::PH_ERROR;
            end
        end

        // Any character that is not a digit of the current radix ends the number as a suffix.
        if (do_digits) begin
            if (dig_ok) begin
                do_add     = 1'b1;
                phase_next = ssp_pkg::PH_DIGITS;
            end else begin
                suffix_next = ch;
                phase_next  = ssp_pkg::PH_SUFFIX;
            end
        end

        if (do_add) begin
            acc_next        = add_acc;
            ovf_next        = add_ovf;
            digit_seen_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= ssp_pkg::PH_LEAD;
            radix_reg      <= ssp_pkg::RADIX_DEC;
            acc_reg        <= '0;
            digit_seen_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            suffix_reg     <= ssp_pkg::CH_NUL;
        end else if (in_fire) begin
            if (ch == ssp_pkg::CH_NUL) begin
                phase_reg      <= ssp_pkg::PH_LEAD;
                radix_reg      <= ssp_pkg::RADIX_DEC;
                acc_reg        <= '0;
                digit_seen_reg <= 1'b0;
                ovf_reg        <= 1'b0;
                suffix_reg     <= ssp_pkg::CH_NUL;
            end else begin
                phase_reg      <= phase_next;
                radix_reg      <= radix_next;
                acc_reg        <= acc_next;
                digit_seen_reg <= digit_seen_next;
                ovf_reg        <= ovf_next;
                suffix_reg     <= suffix_next;
            end
        end
    end

    // Finish decision, valid in the cycle the NUL is accepted.
    logic                           number_done;
    logic                           sfx_hit;
    logic [ssp_pkg::SH_W-1:0]       sfx_sh;
    logic                           sh_ovf;
    logic [ssp_pkg::VAL_W-1:0]      unit_eff;

    always_comb begin
        sfx_hit = 1'b1;
        sfx_sh  = ssp_pkg::SH_BYTE;
        case (suffix_reg) inside
            ssp_pkg::CH_LB:                 sfx_sh = b_means_bytes ? ssp_pkg::SH_BYTE
                                                                   : ssp_pkg::SH_BLOCK;
            ssp_pkg::CH_UK, ssp_pkg::CH_LK: sfx_sh = ssp_pkg::SH_KILO;
            ssp_pkg::CH_UM, ssp_pkg::CH_LM: sfx_sh = ssp_pkg::SH_MEGA;
            ssp_pkg::CH_UG, ssp_pkg::CH_LG: sfx_sh = ssp_pkg::SH_GIGA;
            ssp_pkg::CH_UT, ssp_pkg::CH_LT: sfx_sh = ssp_pkg::SH_TERA;
            ssp_pkg::CH_UP, ssp_pkg::CH_LP: sfx_sh = ssp_pkg::SH_PETA;
            ssp_pkg::CH_UE, ssp_pkg::CH_LE: sfx_sh = ssp_pkg::SH_EXA;
            default:                        sfx_hit = 1'b0;
        endcase

        number_done = (phase_reg == ssp_pkg::PH_DIGITS) ||
                      (phase_reg == ssp_pkg::PH_PREFIX &&
                       radix_reg == ssp_pkg::RADIX_OCT);
        sh_ovf      = (acc_reg & ~(ssp_pkg::ALL_ONES >> sfx_sh)) != '0;
        unit_eff    = (default_unit == '0) ? {{(ssp_pkg::VAL_W-1){1'b0}}, 1'b1}
                                           : default_unit;

        fin.status = ssp_pkg::ST_BAD;
        fin.mul_en = 1'b0;
        fin.size   = '0;
        fin.unit   = default_unit;
        if (ovf_reg) begin
            fin.status = ssp_pkg::ST_OVF;
        end else if (number_done && digit_seen_reg) begin
            fin.status = ssp_pkg::ST_OK;
            fin.mul_en = 1'b1;
            fin.size   = acc_reg;
            fin.unit   = unit_eff;
        end else if (phase_reg == ssp_pkg::PH_SUFFIX && digit_seen_reg && sfx_hit) begin
            if (sh_ovf) begin
                fin.status = ssp_pkg::ST_OVF;
            end else begin
                fin.status = ssp_pkg::ST_OK;
                fin.size   = acc_reg << sfx_sh;
                fin.unit   = {{(ssp_pkg::VAL_W-1){1'b0}}, 1'b1} << sfx_sh;
            end
        end
    end

    // The string always restarts from a clean state after its NUL.
    a_clear_after_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && ch == ssp_pkg::CH_NUL |=>
            phase_reg == ssp_pkg::PH_LEAD && acc_reg == '0 && !ovf_reg && !digit_seen_reg)
        else $error("parse state not cleared after end of string");

    // Overflow saturates the accumulator.
    a_ovf_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> acc_reg == ssp_pkg::ALL_ONES)
        else $error("overflow flag set with unsaturated accumulator");

    // Overflow is sticky within one string.
    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg && in_fire && ch != ssp_pkg::CH_NUL |=> ovf_reg)
        else $error("overflow flag dropped before end of string");

endmodule

@@ hw/rtl/ssp_scaler.sv @@
// Scaling pipeline of the size suffix string parser: 32-bit partial
// products in the first stage, their sum in the output register.
// Depends on ssp_pkg.
module ssp_scaler (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        fin_valid,
    input  ssp_pkg::fin_t               fin,
    output logic                        fin_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  out_status,
    output logic [ssp_pkg::VAL_W-1:0]   out_size,
    output logic [ssp_pkg::VAL_W-1:0]   out_unit
);

    logic                           s1_valid_reg;
    ssp_pkg::fin_t                  s1_fin_reg;
    logic [ssp_pkg::VAL_W-1:0]      pp_ll_reg;
    logic [ssp_pkg::HALF_W-1:0]     pp_lh_reg;
    logic [ssp_pkg::HALF_W-1:0]     pp_hl_reg;
    logic                           out_valid_reg;
    ssp_pkg::status_t               out_status_reg;
    logic [ssp_pkg::VAL_W-1:0]      out_size_reg;
    logic [ssp_pkg::VAL_W-1:0]      out_unit_reg;

    logic                           out_free;
    logic                           s1_move;
    logic [ssp_pkg::VAL_W-1:0]      pp_ll_next;
    logic [ssp_pkg::HALF_W-1:0]     pp_lh_next;
    logic [ssp_pkg::HALF_W-1:0]     pp_hl_next;
    logic [ssp_pkg::HALF_W-1:0]     mid_sum;
    logic [ssp_pkg::VAL_W-1:0]      size_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign fin_ready = !s1_valid_reg || out_free;
    assign s1_move   = s1_valid_reg && out_free;

    // Low 64 bits of a 64x64 product; the high-by-high term never lands there.
    assign pp_ll_next = ssp_pkg::VAL_W'(fin.size[ssp_pkg::HALF_W-1:0]) *
                        ssp_pkg::VAL_W'(fin.unit[ssp_pkg::HALF_W-1:0]);
    assign pp_lh_next = ssp_pkg::HALF_W'(fin.size[ssp_pkg::HALF_W-1:0] *
                                         fin.unit[ssp_pkg::VAL_W-1:ssp_pkg::HALF_W]);
    assign pp_hl_next = ssp_pkg::HALF_W'(fin.size[ssp_pkg::VAL_W-1:ssp_pkg::HALF_W] *
                                         fin.unit[ssp_pkg::HALF_W-1:0]);

    assign mid_sum   = pp_lh_reg + pp_hl_reg;
    assign size_next = s1_fin_reg.mul_en ? pp_ll_reg + {mid_sum, {ssp_pkg::HALF_W{1'b0}}}
                                         : s1_fin_reg.size;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (fin_ready) begin
            s1_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_ready && fin_valid) begin
            s1_fin_reg <= fin;
            pp_ll_reg  <= pp_ll_next;
            pp_lh_reg  <= pp_lh_next;
            pp_hl_reg  <= pp_hl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            out_status_reg <= s1_fin_reg.status;
            out_size_reg   <= size_next;
            out_unit_reg   <= s1_fin_reg.unit;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_size   = out_size_reg;
    assign out_unit   = out_unit_reg;

    // A failed parse reports no size.
    a_size_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg != ssp_pkg::ST_OK |-> out_size_reg == '0)
        else $error("nonzero size on a failed parse");

    // A stage that cannot drain keeps its request.
    a_s1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_fin_reg))
        else $error("first stage request lost under back-pressure");

    // A successful parse always applies a nonzero unit.
    a_unit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg == ssp_pkg::ST_OK |-> out_unit_reg != '0)
        else $error("zero unit on a successful parse");

endmodule

@@ verif/size_suffix_string_parser_test.sv @@
// Self-checking testbench for size_suffix_string_parser: a directed table and random
// size strings, checked against an in-bench parser model. Needs ssp_pkg and the RTL.
`timescale 1ns / 1ps

module size_suffix_string_parser_test;

    localparam int  TAIL_CYCLES  = 8;          // tail wait after the last result, for margin
    localparam int  HOLD_CYCLES  = 40;         // long receiver hold-off
    localparam int  PHASE_CHARS  = 190;        // random characters per register setting
    localparam int  NUM_DIR      = 26;
    localparam real LIMIT_NS     = 10_000_000.0;

    // Suffix letters accepted by the block, highest byte first.
    localparam logic [14*8-1:0] SUFFIX_SET = {
        ssp_pkg::CH_LE, ssp_pkg::CH_UE, ssp_pkg::CH_LP, ssp_pkg::CH_UP,
        ssp_pkg::CH_LT, ssp_pkg::CH_UT, ssp_pkg::CH_LG, ssp_pkg::CH_UG,
        ssp_pkg::CH_LM, ssp_pkg::CH_UM, ssp_pkg::CH_LK, ssp_pkg::CH_UK,
        ssp_pkg::CH_LB, ssp_pkg::CH_LB};

    typedef struct {
        ssp_pkg::status_t          st;
        logic [ssp_pkg::VAL_W-1:0] size;
        logic [ssp_pkg::VAL_W-1:0] unit;
    } outcome_t;

    typedef struct {
        string                     text;
        bit                        typed;   // expected result given in the row
        ssp_pkg::status_t          st;
        logic [ssp_pkg::VAL_W-1:0] size;
        logic [ssp_pkg::VAL_W-1:0] unit;
    } dir_row_t;

    typedef logic [ssp_pkg::CH_W-1:0] text_t [$];

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ssp_pkg::CH_W-1:0]       s_tdata  = '0;    // [7:0] ch
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ssp_pkg::OUT_W-1:0]      m_tdata;          // [1:0] status, [65:2] size_bytes,
                                                      // [129:66] unit_bytes
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [ssp_pkg::PADDR_W-1:0]    paddr    = '0;
    logic [ssp_pkg::PDATA_W-1:0]    pwdata   = '0;
    logic [ssp_pkg::PDATA_W-1:0]    prdata;
    logic                           pready;

    size_suffix_string_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Model copy of the registers and of the parse state.
    logic                       cfg_b_bytes = 1'b0;
    logic [ssp_pkg::VAL_W-1:0]  cfg_unit    = '0;
    ssp_pkg::phase_t            pr_phase    = ssp_pkg::PH_LEAD;
    logic [ssp_pkg::VAL_W-1:0]  pr_acc      = '0;
    ssp_pkg::radix_t            pr_radix    = ssp_pkg::RADIX_DEC;
    logic                       pr_digit    = 1'b0;
    logic                       pr_ovf      = 1'b0;
    logic [ssp_pkg::CH_W-1:0]   pr_suffix   = '0;

    outcome_t outcome_q [$];
    outcome_t typed_outcome;
    bit       use_typed    = 1'b0;
    bit       idle_on      = 1'b1;
    int       hold_asks    = 0;
    int       err_cnt      = 0;
    int       chars_sent   = 0;
    int       strings_sent = 0;
    int       results_seen = 0;
    int       settings     = 1;

    // Directed strings, run with the reset register values (b means blocks,
    // default unit zero, so a failed parse reports unit zero).
    dir_row_t dir_tab [NUM_DIR] = '{
        '{"",                      1'b1, ssp_pkg::ST_BAD, 64'd0,    64'd0},
        '{"0",                     1'b1, ssp_pkg::ST_OK,  64'd0,    64'd1},
        '{"18446744073709551615",  1'b1, ssp_pkg::ST_OK,  ssp_pkg::ALL_ONES, 64'd1},
        '{"18446744073709551616",  1'b1, ssp_pkg::ST_OVF, 64'd0,    64'd0},
        '{" \t\n\013\014\015+7",   1'b1, ssp_pkg::ST_OK,  64'd7,    64'd1},
        '{"  -5",                  1'b1, ssp_pkg::ST_BAD, 64'd0,    64'd0},
        '{"+",                     1'b1, ssp_pkg::ST_BAD, 64'd0,    64'd0},
        '{"+x",                    1'b1, ssp_pkg::ST_BAD, 64'd0,    64'd0},
        '{"0x",                    1'b1, ssp_pkg::ST_BAD, 64'd0,    64'd0},
        '{"08",                    1'b1, ssp_pkg::ST_BAD, 64'd0,    64'd0},
        '{"0b",                    1'b1, ssp_pkg::ST_OK,  64'd0,    64'd512},
        '{"3b",                    1'b1, ssp_pkg::ST_OK,  64'd1536, 64'd512},
        '{"2k",                    1'b1, ssp_pkg::ST_OK,  64'd2048, 64'd1024},
        '{"15E",                   1'b1, ssp_pkg::ST_OK,  64'hF000_0000_0000_0000,
                                                          64'h1000_0000_0000_0000},
        '{"16E",                   1'b1, ssp_pkg::ST_OVF, 64'd0,    64'd0},
        '{"12 ",                   1'b1, ssp_pkg::ST_BAD, 64'd0,    64'd0},
        '{"5KB",                   1'b1, ssp_pkg::ST_BAD, 64'd0,    64'd0},
        '{"7q",                    1'b1, ssp_pkg::ST_BAD, 64'd0,    64'd0},
        '{"99999999999999999999x", 1'b1, ssp_pkg::ST_OVF, 64'd0,    64'd0},
        '{"\377 5",                1'b1, ssp_pkg::ST_BAD, 64'd0,    64'd0},
        '{"36028797018963968b",    1'b1, ssp_pkg::ST_OVF, 64'd0,    64'd0},
        '{"0xabcDEF0123456789",    1'b0, ssp_pkg::ST_OK,  64'd0,    64'd0},
        '{"0777",                  1'b0, ssp_pkg::ST_OK,  64'd0,    64'd0},
        '{"0x1P",                  1'b0, ssp_pkg::ST_OK,  64'd0,    64'd0},
        '{"36028797018963967b",    1'b0, ssp_pkg::ST_OK,  64'd0,    64'd0},
        '{"+0X10g",                1'b0, ssp_pkg::ST_OK,  64'd0,    64'd0}
    };

    // ---------------------------------------------------------------
    // Parser model
    // ---------------------------------------------------------------

    function automatic int digit_of(input logic [ssp_pkg::CH_W-1:0] c,
                                    input ssp_pkg::radix_t r);
        int v;
        v = -1;
        if (c >= ssp_pkg::CH_0 && c <= ssp_pkg::CH_9) begin
            v = int'(c) - int'(ssp_pkg::CH_0);
        end else if (c >= ssp_pkg::CH_LA && c <= ssp_pkg::CH_LF) begin
            v = int'(c) - int'(ssp_pkg::CH_LA) + 10;
        end else if (c >= ssp_pkg::CH_UA && c <= ssp_pkg::CH_UF) begin
            v = int'(c) - int'(ssp_pkg::CH_UA) + 10;
        end
        if (v < 0 || r == ssp_pkg::RADIX_HEX) return v;
        if (r == ssp_pkg::RADIX_OCT) return (v < 8) ? v : -1;
        return (v < 10) ? v : -1;
    endfunction

    // Multiply-add into the accumulator; once past 64 bits it sticks at all ones.
    task automatic take_digit(input int d);
        logic [ssp_pkg::VAL_W-1:0] base;
        logic [ssp_pkg::VAL_W-1:0] ud;
        base = (pr_radix == ssp_pkg::RADIX_HEX) ? 64'd16 :
               ((pr_radix == ssp_pkg::RADIX_OCT) ? 64'd8 : 64'd10);
        ud   = 64'(d);
        if (pr_ovf || pr_acc > (ssp_pkg::ALL_ONES - ud) / base) begin
            pr_ovf = 1'b1;
            pr_acc = ssp_pkg::ALL_ONES;
        end else begin
            pr_acc = pr_acc * base + ud;
        end
        pr_digit = 1'b1;
    endtask

    task automatic start_number(input logic [ssp_pkg::CH_W-1:0] c);
        if (c == ssp_pkg::CH_0) begin
            pr_phase = ssp_pkg::PH_PREFIX;
            pr_radix = ssp_pkg::RADIX_OCT;
            pr_digit = 1'b1;
        end else if (c >= ssp_pkg::CH_1 && c <= ssp_pkg::CH_9) begin
            pr_radix = ssp_pkg::RADIX_DEC;
            take_digit(int'(c) - int'(ssp_pkg::CH_0));
            pr_phase = ssp_pkg::PH_DIGITS;
        end else begin
            pr_phase = ssp_pkg::PH_ERROR;
        end
    endtask

    // A character that is no digit of the radix ends the number as a suffix.
    task automatic continue_number(input logic [ssp_pkg::CH_W-1:0] c);
        int d;
        d = digit_of(c, pr_radix);
        if (d >= 0) begin
            take_digit(d);
            pr_phase = ssp_pkg::PH_DIGITS;
        end else begin
            pr_suffix = c;
            pr_phase  = ssp_pkg::PH_SUFFIX;
        end
    endtask

    task automatic parse_char(input logic [ssp_pkg::CH_W-1:0] c);
        int d;
        case (pr_phase)
            ssp_pkg::PH_LEAD: begin
                if (c == ssp_pkg::CH_MINUS) begin
                    pr_phase = ssp_pkg::PH_ERROR;
                end else if (c == ssp_pkg::CH_PLUS) begin
                    pr_phase = ssp_pkg::PH_SIGNED;
                end else if (!(c == ssp_pkg::CH_SPACE ||
                               (c >= ssp_pkg::CH_TAB && c <= ssp_pkg::CH_CR))) begin
                    start_number(c);
                end
            end
            ssp_pkg::PH_SIGNED: start_number(c);
            ssp_pkg::PH_PREFIX: begin
                if (pr_radix == ssp_pkg::RADIX_HEX) begin
                    d = digit_of(c, pr_radix);
                    if (d < 0) begin
                        pr_phase = ssp_pkg::PH_ERROR;
                    end else begin
                        take_digit(d);
                        pr_phase = ssp_pkg::PH_DIGITS;
                    end
                end else if (c == ssp_pkg::CH_LX || c == ssp_pkg::CH_UX) begin
                    pr_radix = ssp_pkg::RADIX_HEX;
                end else begin
                    continue_number(c);
                end
            end
            ssp_pkg::PH_DIGITS: continue_number(c);
            default:            pr_phase = ssp_pkg::PH_ERROR;
        endcase
    endtask

    // Outcome of the NUL that ends a string; parse state goes back to reset.
    function automatic outcome_t close_string();
        outcome_t                  r;
        logic [ssp_pkg::VAL_W-1:0] u;
        logic [ssp_pkg::SH_W-1:0]  sh;
        bit                        known;
        r.st   = ssp_pkg::ST_BAD;
        r.size = '0;
        r.unit = cfg_unit;
        known  = 1'b1;
        sh     = ssp_pkg::SH_BYTE;
        if (pr_ovf) begin
            r.st = ssp_pkg::ST_OVF;
        end else if (pr_digit && (pr_phase == ssp_pkg::PH_DIGITS ||
                     (pr_phase == ssp_pkg::PH_PREFIX &&
                      pr_radix == ssp_pkg::RADIX_OCT))) begin
            u      = (cfg_unit == 0) ? 64'd1 : cfg_unit;
            r.st   = ssp_pkg::ST_OK;
            r.size = pr_acc * u;
            r.unit = u;
        end else if (pr_digit && pr_phase == ssp_pkg::PH_SUFFIX) begin
            case (pr_suffix)
                ssp_pkg::CH_LB:
                    sh = cfg_b_bytes ? ssp_pkg::SH_BYTE : ssp_pkg::SH_BLOCK;
                ssp_pkg::CH_UK, ssp_pkg::CH_LK: sh = ssp_pkg::SH_KILO;
                ssp_pkg::CH_UM, ssp_pkg::CH_LM: sh = ssp_pkg::SH_MEGA;
                ssp_pkg::CH_UG, ssp_pkg::CH_LG: sh = ssp_pkg::SH_GIGA;
                ssp_pkg::CH_UT, ssp_pkg::CH_LT: sh = ssp_pkg::SH_TERA;
                ssp_pkg::CH_UP, ssp_pkg::CH_LP: sh = ssp_pkg::SH_PETA;
                ssp_pkg::CH_UE, ssp_pkg::CH_LE: sh = ssp_pkg::SH_EXA;
                default:                        known = 1'b0;
            endcase
            if (known) begin
                if (pr_acc > (ssp_pkg::ALL_ONES >> sh)) begin
                    r.st = ssp_pkg::ST_OVF;
                end else begin
                    r.st   = ssp_pkg::ST_OK;
                    r.size = pr_acc << sh;
                    r.unit = 64'd1 << sh;
                end
            end
        end
        if (r.st != ssp_pkg::ST_OK) begin
            r.size = '0;
            r.unit = cfg_unit;
        end
        pr_phase  = ssp_pkg::PH_LEAD;
        pr_acc    = '0;
        pr_radix  = ssp_pkg::RADIX_DEC;
        pr_digit  = 1'b0;
        pr_ovf    = 1'b0;
        pr_suffix = '0;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Idle length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one character and waits for the request to be taken. The model
    // runs at the accepting edge, so its expectation is queued before the
    // result can come back through the first stage and output registers.
    task automatic send_char(input logic [ssp_pkg::CH_W-1:0] c);
        int       gap;
        outcome_t res;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
        if (c != ssp_pkg::CH_NUL) begin
            parse_char(c);
        end else begin
            res = close_string();
            if (use_typed) res = typed_outcome;
            outcome_q.push_back(res);
            strings_sent++;
        end
    endtask

    task automatic send_text(input text_t t);
        foreach (t[i]) send_char(t[i]);
        send_char(ssp_pkg::CH_NUL);
    endtask

    // Drops valid and waits until every queued result has come back.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Register write followed by a read back of the same register.
    task automatic write_reg(input logic idx, input logic [ssp_pkg::PDATA_W-1:0] value);
        logic [ssp_pkg::PDATA_W-1:0] want;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == ssp_pkg::REG_B_MEANS_BYTES) begin
            cfg_b_bytes = value[0];
            want        = {{(ssp_pkg::PDATA_W-1){1'b0}}, value[0]};
        end else begin
            cfg_unit = value;
            want     = value;
        end
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register %0d read back expected %h actual %h",
                     $time, idx, want, prdata);
            err_cnt++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random size string without its NUL. Most are well formed: optional
    // whitespace and sign, a decimal, octal or hex number and maybe a suffix.
    // The rest is raw noise or a well-formed string with one stray byte added.
    function automatic text_t make_size_text();
        text_t q;
        int    k;
        int    len;
        int    v;
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(0, 8)) q.push_back(8'($urandom_range(1, 255)));
            return q;
        end
        repeat ($urandom_range(0, 2)) begin
            k = $urandom_range(0, 5);
            q.push_back((k == 5) ? ssp_pkg::CH_SPACE : 8'(ssp_pkg::CH_TAB + k));
        end
        k = $urandom_range(0, 9);
        if (k == 0) q.push_back(ssp_pkg::CH_PLUS);
        if (k == 1) q.push_back(ssp_pkg::CH_MINUS);
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
        k = $urandom_range(0, 9);
        if (k < 6) begin
            q.push_back(8'(ssp_pkg::CH_1 + $urandom_range(0, 8)));
            repeat (len - 1) q.push_back(8'(ssp_pkg::CH_0 + $urandom_range(0, 9)));
        end else if (k < 8) begin
            q.push_back(ssp_pkg::CH_0);
            repeat (len - 1) q.push_back(8'(ssp_pkg::CH_0 + $urandom_range(0, 7)));
        end else begin
            q.push_back(ssp_pkg::CH_0);
            q.push_back($urandom_range(0, 1) ? ssp_pkg::CH_LX : ssp_pkg::CH_UX);
            repeat (len) begin
                v = $urandom_range(0, 15);
                if (v < 10) q.push_back(8'(ssp_pkg::CH_0 + v));
                else q.push_back(8'(($urandom_range(0, 1) ? ssp_pkg::CH_LA : ssp_pkg::CH_UA)
                                    + v - 10));
            end
        end
        k = $urandom_range(0, 9);
        if (k >= 4 && k < 9) q.push_back(SUFFIX_SET[$urandom_range(0, 13)*8 +: 8]);
        if (k == 9) q.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(0, 2);
            if (k == 0) q.push_back(8'($urandom_range(1, 255)));
            if (k == 1) q.insert($urandom_range(0, q.size()), 8'($urandom_range(1, 255)));
            if (k == 2) q.push_back(ssp_pkg::CH_SPACE);
        end
        return q;
    endfunction

    // ---------------------------------------------------------------
    // Receiver: random ready pattern, plus a long hold-off on request.
    // ---------------------------------------------------------------
    initial begin : rx_ready
        int hold_done;
        int rx_left;
        bit rx_level;
        int g;
        hold_done = 0;
        rx_left   = 0;
        rx_level  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_done != hold_asks) begin
                hold_done++;
                rx_level = 1'b0;
                rx_left  = HOLD_CYCLES;
            end else if (rx_left <= 0) begin
                if (!idle_on) begin
                    rx_level = 1'b1;
                    rx_left  = 1;
                end else if (rx_level) begin
                    g = pick_gap();
                    if (g > 0) begin
                        rx_level = 1'b0;
                        rx_left  = g;
                    end else begin
                        rx_left = $urandom_range(1, 8);
                    end
                end else begin
                    rx_level = 1'b1;
                    rx_left  = $urandom_range(1, 12);
                end
            end
            m_tready <= rx_level;
            rx_left--;
        end
    end

    // ---------------------------------------------------------------
    // Result check: each accepted result against the oldest expectation.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        outcome_t                  want;
        logic [1:0]                got_st;
        logic [ssp_pkg::VAL_W-1:0] got_size;
        logic [ssp_pkg::VAL_W-1:0] got_unit;
        if (aresetn && m_tvalid && m_tready) begin
            got_st   = m_tdata[1:0];
            got_size = m_tdata[2 +: ssp_pkg::VAL_W];
            got_unit = m_tdata[2 + ssp_pkg::VAL_W +: ssp_pkg::VAL_W];
            results_seen++;
            if (outcome_q.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d size %h unit %h",
                         $time, got_st, got_size, got_unit);
                err_cnt++;
            end else begin
                want = outcome_q.pop_front();
                if (got_st !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, got_st);
                    err_cnt++;
                end
                if (got_size !== want.size) begin
                    $display("%0t: size_bytes expected %h actual %h",
                             $time, want.size, got_size);
                    err_cnt++;
                end
                if (got_unit !== want.unit) begin
                    $display("%0t: unit_bytes expected %h actual %h",
                             $time, want.unit, got_unit);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : main_seq
        text_t t;
        text_t burst;
        int    ph;
        int    goal;
        bit    paused;
        logic  b_val;
        logic [ssp_pkg::VAL_W-1:0] u_val;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table with the reset register values.
        for (int r = 0; r < NUM_DIR; r++) begin
            t.delete();
            for (int i = 0; i < dir_tab[r].text.len(); i++) t.push_back(dir_tab[r].text[i]);
            use_typed           = dir_tab[r].typed;
            typed_outcome.st   = dir_tab[r].st;
            typed_outcome.size = dir_tab[r].size;
            typed_outcome.unit = dir_tab[r].unit;
            send_text(t);
        end
        use_typed = 1'b0;
        wait_idle();

        // Random strings under several register settings, extremes included.
        for (ph = 1; ph <= 6; ph++) begin
            case (ph)
                1:       begin b_val = 1'b1; u_val = 64'd1;                       end
                2:       begin b_val = 1'b0; u_val = ssp_pkg::ALL_ONES;           end
                3:       begin b_val = 1'b1; u_val = {$urandom, $urandom};        end
                4:       begin b_val = 1'b0; u_val = 64'($urandom_range(2, 4096)); end
                5:       begin b_val = 1'b1; u_val = 64'd0;                       end
                default: begin b_val = 1'b0; u_val = 64'h8000_0000_0000_0000;     end
            endcase
            write_reg(ssp_pkg::REG_B_MEANS_BYTES, 64'(b_val));
            write_reg(ssp_pkg::REG_DEFAULT_UNIT, u_val);
            settings++;
            idle_on = (ph != 4);

            // Back-pressure: the receiver stalls while short strings keep
            // coming with no gaps, so both result stages fill and the input
            // stream has to stall.
            if (ph == 2) begin
                idle_on = 1'b0;
                hold_asks++;
                burst.delete();
                burst.push_back(ssp_pkg::CH_1);
                burst.push_back(ssp_pkg::CH_9);
                burst.push_back(ssp_pkg::CH_UK);
                repeat (8) send_text(burst);
                idle_on = 1'b1;
            end

            goal   = chars_sent + PHASE_CHARS;
            paused = 1'b0;
            while (chars_sent < goal) begin
                send_text(make_size_text());
                // Sender pause until everything in flight has come back.
                if (ph == 3 && !paused && chars_sent > goal - PHASE_CHARS / 2) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
            wait_idle();
        end

        $display("Covered %0d characters in %0d strings under %0d register settings;",
                 chars_sent, strings_sent, settings);
        $display("%0d results compared, including a long receiver stall.", results_seen);
        if (err_cnt == 0 && outcome_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("Run did not finish in time with %0d results outstanding.", outcome_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
